// ----- sv/csor_pkg.sv -----
// shared types, constants and saturating fixed-point helpers of the cell update
package csor_pkg;

    localparam int GRID_CELLS_DEF = 4096;
    localparam int DIV_BITS       = 48;
    localparam int PADDR_W        = 4;

    localparam logic [1:0] REG_ROW_LENGTH   = 2'd0;
    localparam logic [1:0] REG_CELL_COUNT   = 2'd1;
    localparam logic [1:0] REG_RELAX_FACTOR = 2'd2;
    localparam logic [1:0] REG_CHARGE_COEF  = 2'd3;

    localparam logic [12:0] ROW_LENGTH_RST   = 13'd64;
    localparam logic [12:0] CELL_COUNT_RST   = 13'd4096;
    localparam logic [16:0] RELAX_FACTOR_RST = 17'd127795;
    localparam logic signed [31:0] CHARGE_COEF_RST = 32'sd65536;

    localparam logic signed [31:0] Q_ONE   = 32'sd65536;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;

    typedef struct packed {
        logic        operation;
        logic [11:0] cell_index;
        logic signed [31:0] load_value;
        logic [30:0] radial_step_down;
        logic [30:0] radial_step_up;
        logic [30:0] axial_step_down;
        logic [30:0] axial_step_up;
        logic [30:0] radius;
        logic signed [31:0] impurity;
        logic        fixed_cell;
        logic        clamp_mode;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] new_potential;
        logic        depleted;
        logic        skipped;
    } t_out_item;

    typedef struct packed {
        logic        start;
        logic        shift;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic signed [31:0] q;
        logic [31:0] rem;
    } t_div_rsp;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_RELAX = 1'b1;

    function automatic logic signed [31:0] qadd(logic signed [31:0] a, logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        if (s > 33'sd2147483647)       return S32_MAX;
        else if (s < -33'sd2147483648) return S32_MIN;
        else                           return s[31:0];
    endfunction

    function automatic logic signed [31:0] qsub(logic signed [31:0] a, logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) - 33'(b);
        if (s > 33'sd2147483647)       return S32_MAX;
        else if (s < -33'sd2147483648) return S32_MIN;
        else                           return s[31:0];
    endfunction

    function automatic logic signed [31:0] qmul(logic signed [31:0] a, logic signed [32:0] b);
        logic signed [64:0] p;
        logic signed [64:0] f;
        p = 65'(a) * 65'(b);
        f = p >>> 16;
        if (f > 65'sd2147483647)       return S32_MAX;
        else if (f < -65'sd2147483648) return S32_MIN;
        else                           return f[31:0];
    endfunction

endpackage

// ----- sv/csor_div.sv -----
// shared radix-2 restoring divider, signed saturating Q16.16 quotient or plain remainder
module csor_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  csor_pkg::t_div_req i_req,
    output csor_pkg::t_div_rsp o_rsp
);

    localparam int CW = $clog2(csor_pkg::DIV_BITS);

    logic                r_busy;
    logic [CW-1:0]       r_cnt;
    logic                r_done;
    logic [csor_pkg::DIV_BITS-1:0] r_quo;
    logic [31:0]         r_rem;
    logic [31:0]         r_bm;
    logic                r_neg;
    logic                r_bz;
    logic                r_apos;
    logic                r_azero;

    logic [32:0] am;
    logic [32:0] bm;
    logic [32:0] rem_sh;
    logic        ge;
    logic [32:0] rem_sub;

    always_comb begin
        am      = i_req.a[31] ? -33'(i_req.a) : 33'(i_req.a);
        bm      = i_req.b[31] ? -33'(i_req.b) : 33'(i_req.b);
        rem_sh  = {r_rem, r_quo[csor_pkg::DIV_BITS-1]};
        ge      = rem_sh >= {1'b0, r_bm};
        rem_sub = rem_sh - {1'b0, r_bm};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_req.start) begin
                r_done  <= 1'b0;
                r_busy  <= 1'b1;
                r_cnt   <= '0;
                r_rem   <= '0;
                r_bm    <= bm[31:0];
                r_neg   <= i_req.a[31] ^ i_req.b[31];
                r_bz    <= (i_req.b == '0);
                r_apos  <= !i_req.a[31] && (i_req.a != '0);
                r_azero <= (i_req.a == '0);
                r_quo   <= i_req.shift ? {am[31:0], 16'd0} : {16'd0, am[31:0]};
            end else if (r_busy) begin
                r_rem <= ge ? rem_sub[31:0] : rem_sh[31:0];
                r_quo <= {r_quo[csor_pkg::DIV_BITS-2:0], ge};
                if (r_cnt == CW'(csor_pkg::DIV_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt  <= r_cnt + 1'b1;
                    r_done <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    always_comb begin
        o_rsp.done = r_done;
        o_rsp.rem  = r_rem;
        if (r_bz) begin
            if (r_apos)       o_rsp.q = csor_pkg::S32_MAX;
            else if (r_azero) o_rsp.q = '0;
            else              o_rsp.q = csor_pkg::S32_MIN;
        end else if (!r_neg) begin
            o_rsp.q = (r_quo > 48'h7FFFFFFF) ? csor_pkg::S32_MAX : r_quo[31:0];
        end else begin
            o_rsp.q = (r_quo > 48'h80000000) ? csor_pkg::S32_MIN : -r_quo[31:0];
        end
    end

endmodule

// ----- sv/cylindrical_sor_cell_update.sv -----
// top level: potential grid memory, register port and sequencer of one cell update
// A load passes through the finish state into the output register. A relax item takes one
// index remainder and fifteen Q16.16 divisions through the one shared divider, plus memory
// reads of the cell and its four neighbours and the density and relaxation products (two
// divisions fewer when the radius is zero). One item is worked on at a time; the finished
// result sits in an output register so the next item can enter while it waits to be taken.
// The grid memory has no reset; a cell must be loaded before a relax item reads it.
module cylindrical_sor_cell_update #(
    parameter int GRID_CELLS = csor_pkg::GRID_CELLS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  csor_pkg::t_in_item    i_in_data,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output csor_pkg::t_out_item   o_out_data,
    input  logic                  i_out_stall,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [csor_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int AW = $clog2(GRID_CELLS);
    localparam int NW = (AW > 13 ? AW : 13) + 2;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_MOD_GO   = 4'd1;
    localparam logic [3:0] S_MOD_WAIT = 4'd2;
    localparam logic [3:0] S_READ     = 4'd3;
    localparam logic [3:0] S_DENS     = 4'd4;
    localparam logic [3:0] S_DIV_GO   = 4'd5;
    localparam logic [3:0] S_DIV_WAIT = 4'd6;
    localparam logic [3:0] S_MULT     = 4'd7;
    localparam logic [3:0] S_FIN      = 4'd8;

    // division steps of the update
    localparam logic [3:0] U_DIFF_R  = 4'd0;
    localparam logic [3:0] U_T1      = 4'd1;
    localparam logic [3:0] U_PRP     = 4'd2;
    localparam logic [3:0] U_PRM     = 4'd3;
    localparam logic [3:0] U_T2      = 4'd4;
    localparam logic [3:0] U_PZP     = 4'd5;
    localparam logic [3:0] U_PZM     = 4'd6;
    localparam logic [3:0] U_T3      = 4'd7;
    localparam logic [3:0] U_INV_DRM = 4'd8;
    localparam logic [3:0] U_INV_DRP = 4'd9;
    localparam logic [3:0] U_D2      = 4'd10;
    localparam logic [3:0] U_INV_DZP = 4'd11;
    localparam logic [3:0] U_INV_DZM = 4'd12;
    localparam logic [3:0] U_D3      = 4'd13;
    localparam logic [3:0] U_TARGET  = 4'd14;

    localparam logic [2:0] RD_LAST = 3'd5;

    logic [12:0] r_row_len;
    logic [12:0] r_cell_cnt;
    logic [16:0] r_relax;
    logic signed [31:0] r_charge;

    logic [3:0]  r_state;
    logic [3:0]  r_step;
    logic [2:0]  r_rcnt;
    csor_pkg::t_in_item r_item;
    logic [12:0] r_col;

    logic signed [31:0] r_old, r_pzm, r_pzp, r_prm, r_prp;
    logic signed [31:0] r_dens, r_sr, r_sz, r_x, r_t1, r_t2, r_t3, r_num, r_den, r_target;

    logic signed [31:0] r_res_val;
    logic        r_res_dep;
    logic        r_res_skip;

    logic        r_out_valid;
    csor_pkg::t_out_item r_out;

    logic [31:0] r_grid [GRID_CELLS];
    logic [31:0] r_rdata;

    logic [12:0]   n1;
    logic [NW-1:0] n_eff;
    logic [NW-1:0] in_idx;
    logic [NW-1:0] idx;
    logic [NW-1:0] izm, izp, irm, irp;
    logic [NW-1:0] rd_idx;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic          accept;
    logic          out_free;

    csor_pkg::t_div_req div_req;
    csor_pkg::t_div_rsp div_rsp;

    logic signed [31:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [31:0] mul_res;
    logic signed [31:0] relaxed;
    logic signed [31:0] lo, hi;
    logic        dep;
    logic signed [31:0] stored;
    logic signed [31:0] sum2;

    assign pready      = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign out_free    = !r_out_valid || !i_out_stall;

    always_comb begin
        case (paddr[3:2])
            csor_pkg::REG_ROW_LENGTH:   prdata = {19'd0, r_row_len};
            csor_pkg::REG_CELL_COUNT:   prdata = {19'd0, r_cell_cnt};
            csor_pkg::REG_RELAX_FACTOR: prdata = {15'd0, r_relax};
            csor_pkg::REG_CHARGE_COEF:  prdata = r_charge;
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_len  <= csor_pkg::ROW_LENGTH_RST;
            r_cell_cnt <= csor_pkg::CELL_COUNT_RST;
            r_relax    <= csor_pkg::RELAX_FACTOR_RST;
            r_charge   <= csor_pkg::CHARGE_COEF_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                csor_pkg::REG_ROW_LENGTH:   r_row_len  <= pwdata[12:0];
                csor_pkg::REG_CELL_COUNT:   r_cell_cnt <= pwdata[12:0];
                csor_pkg::REG_RELAX_FACTOR: r_relax    <= pwdata[16:0];
                csor_pkg::REG_CHARGE_COEF:  r_charge   <= pwdata;
                default: ;
            endcase
        end
    end

    // neighbour addressing
    always_comb begin
        n1 = (r_row_len == '0) ? 13'd1 : r_row_len;
        if (r_cell_cnt == '0)                    n_eff = NW'(1);
        else if (NW'(r_cell_cnt) > NW'(GRID_CELLS)) n_eff = NW'(GRID_CELLS);
        else                                     n_eff = NW'(r_cell_cnt);
        in_idx = NW'(i_in_data.cell_index);
        idx    = NW'(r_item.cell_index);
        izm = (idx >= NW'(n1)) ? idx - NW'(n1) : idx + NW'(n1);
        if (izm >= n_eff) izm = idx;
        izp = (idx + NW'(n1) >= n_eff) ? idx : idx + NW'(n1);
        irm = (r_col == '0) ? idx : idx - 1'b1;
        irp = ((r_col == n1 - 1'b1) || (idx + 1'b1 >= n_eff)) ? idx : idx + 1'b1;
        case (r_rcnt)
            3'd1:    rd_idx = izm;
            3'd2:    rd_idx = izp;
            3'd3:    rd_idx = irm;
            3'd4:    rd_idx = irp;
            default: rd_idx = idx;
        endcase
    end

    // min and max of the neighbours, density product, relaxation and clamp
    always_comb begin
        lo = r_prm;
        hi = r_prm;
        if (r_prp < lo) lo = r_prp;
        if (r_pzp < lo) lo = r_pzp;
        if (r_pzm < lo) lo = r_pzm;
        if (r_prp > hi) hi = r_prp;
        if (r_pzp > hi) hi = r_pzp;
        if (r_pzm > hi) hi = r_pzm;
        if (r_state == S_DENS) begin
            mul_a = r_item.impurity;
            mul_b = 33'(r_charge);
        end else begin
            mul_a = csor_pkg::qsub(r_target, r_old);
            mul_b = {16'd0, r_relax};
        end
        mul_res = csor_pkg::qmul(mul_a, mul_b);
        relaxed = csor_pkg::qadd(r_old, mul_res);
        dep     = !(relaxed < lo) && !(relaxed > hi);
        if (!dep && r_item.clamp_mode) stored = (relaxed < lo) ? lo : hi;
        else                           stored = relaxed;
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = AW'(idx);
        wr_data = stored;
        if (accept && (in_idx < n_eff) && (i_in_data.operation == csor_pkg::OP_LOAD)) begin
            wr_en   = 1'b1;
            wr_addr = AW'(in_idx);
            wr_data = i_in_data.load_value;
        end else if (r_state == S_MULT) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_grid[wr_addr] <= wr_data;
        r_rdata <= r_grid[AW'(rd_idx)];
    end

    // divider operands of each step
    always_comb begin
        div_req.start = (r_state == S_DIV_GO) || (r_state == S_MOD_GO);
        div_req.shift = (r_state == S_DIV_GO);
        div_req.a     = r_num;
        div_req.b     = r_den;
        if (r_state == S_MOD_GO) begin
            div_req.a = 32'(r_item.cell_index);
            div_req.b = 32'(n1);
        end else begin
            case (r_step)
                U_DIFF_R:  begin div_req.a = csor_pkg::qsub(r_prp, r_prm);
                                 div_req.b = 32'(r_item.radius); end
                U_T1:      begin div_req.a = r_x;   div_req.b = r_sr; end
                U_PRP:     begin div_req.a = r_prp; div_req.b = 32'(r_item.radial_step_up); end
                U_PRM:     begin div_req.a = r_prm; div_req.b = 32'(r_item.radial_step_down); end
                U_T2:      begin div_req.a = r_t2;  div_req.b = r_sr; end
                U_PZP:     begin div_req.a = r_pzp; div_req.b = 32'(r_item.axial_step_up); end
                U_PZM:     begin div_req.a = r_pzm; div_req.b = 32'(r_item.axial_step_down); end
                U_T3:      begin div_req.a = r_t3;  div_req.b = r_sz; end
                U_INV_DRM: begin div_req.a = csor_pkg::Q_ONE;
                                 div_req.b = 32'(r_item.radial_step_down); end
                U_INV_DRP: begin div_req.a = csor_pkg::Q_ONE;
                                 div_req.b = 32'(r_item.radial_step_up); end
                U_D2:      begin div_req.a = r_t2;  div_req.b = r_sr; end
                U_INV_DZP: begin div_req.a = csor_pkg::Q_ONE;
                                 div_req.b = 32'(r_item.axial_step_up); end
                U_INV_DZM: begin div_req.a = csor_pkg::Q_ONE;
                                 div_req.b = 32'(r_item.axial_step_down); end
                U_D3:      begin div_req.a = r_t3;  div_req.b = r_sz; end
                default:   begin div_req.a = r_num; div_req.b = r_den; end
            endcase
        end
        sum2 = csor_pkg::qadd(r_x, div_rsp.q);
    end

    csor_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_rcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_FIN && out_free) r_out_valid <= 1'b1;
            else if (!i_out_stall)            r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_item     <= i_in_data;
                        r_res_val  <= ((in_idx < n_eff) &&
                                       (i_in_data.operation == csor_pkg::OP_LOAD)) ?
                                      i_in_data.load_value : '0;
                        r_res_dep  <= 1'b0;
                        r_res_skip <= 1'b1;
                        if (in_idx >= n_eff) begin
                            r_state <= S_FIN;
                        end else if (i_in_data.operation == csor_pkg::OP_LOAD) begin
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_MOD_GO;
                        end
                    end
                end
                S_MOD_GO: r_state <= S_MOD_WAIT;
                S_MOD_WAIT: begin
                    if (div_rsp.done) begin
                        r_col   <= div_rsp.rem[12:0];
                        r_rcnt  <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    case (r_rcnt)
                        3'd1:    r_old <= r_rdata;
                        3'd2:    r_pzm <= r_rdata;
                        3'd3:    r_pzp <= r_rdata;
                        3'd4:    r_prm <= r_rdata;
                        3'd5:    r_prp <= r_rdata;
                        default: ;
                    endcase
                    r_rcnt <= r_rcnt + 1'b1;
                    if (r_rcnt == RD_LAST) begin
                        r_state <= r_item.fixed_cell ? S_FIN : S_DENS;
                    end
                    // fixed cell reports its stored value
                    if (r_rcnt == 3'd1) r_res_val <= r_rdata;
                end
                S_DENS: begin
                    r_dens  <= mul_res;
                    r_sr    <= csor_pkg::qadd(32'(r_item.radial_step_down),
                                              32'(r_item.radial_step_up));
                    r_sz    <= csor_pkg::qadd(32'(r_item.axial_step_down),
                                              32'(r_item.axial_step_up));
                    r_step  <= U_DIFF_R;
                    r_state <= S_DIV_GO;
                end
                S_DIV_GO: begin
                    // zero radius drops the 1/r term
                    if (r_step == U_DIFF_R && r_item.radius == '0) begin
                        r_t1   <= '0;
                        r_step <= U_PRP;
                    end else begin
                        r_state <= S_DIV_WAIT;
                    end
                end
                S_DIV_WAIT: begin
                    if (div_rsp.done) begin
                        case (r_step)
                            U_T1:      r_t1 <= div_rsp.q;
                            U_PRM:     r_t2 <= csor_pkg::qadd(sum2, sum2);
                            U_T2:      r_t2 <= div_rsp.q;
                            U_PZM:     r_t3 <= csor_pkg::qadd(sum2, sum2);
                            U_T3:      r_num <= csor_pkg::qadd(csor_pkg::qadd(
                                           csor_pkg::qadd(r_dens, r_t1), r_t2), div_rsp.q);
                            U_INV_DRP: r_t2 <= csor_pkg::qadd(sum2, sum2);
                            U_D2:      r_t2 <= div_rsp.q;
                            U_INV_DZM: r_t3 <= csor_pkg::qadd(sum2, sum2);
                            U_D3:      r_den <= csor_pkg::qadd(r_t2, div_rsp.q);
                            U_TARGET:  r_target <= div_rsp.q;
                            default:   r_x <= div_rsp.q;
                        endcase
                        r_step  <= r_step + 1'b1;
                        r_state <= (r_step == U_TARGET) ? S_MULT : S_DIV_GO;
                    end
                end
                S_MULT: begin
                    r_res_val  <= stored;
                    r_res_dep  <= dep;
                    r_res_skip <= 1'b0;
                    r_state    <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out.new_potential <= r_res_val;
                        r_out.depleted      <= r_res_dep;
                        r_out.skipped       <= r_res_skip;
                        r_state             <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- sv/csor_checker.sv -----
// port-level checks of the cell update and their binding to the top level
module csor_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input csor_pkg::t_in_item  i_in_data,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input csor_pkg::t_out_item o_out_data,
    input logic                i_out_stall
);

    a_busy_after_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("block took no time over an item");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("stalled result dropped");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_data))
        else $error("stalled result changed");

    a_skip_not_depleted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.skipped) |-> !o_out_data.depleted)
        else $error("skipped item reported as depleted");

    a_load_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_data.operation == csor_pkg::OP_LOAD)
        |=> o_in_stall)
        else $error("load item not held");

endmodule

bind cylindrical_sor_cell_update csor_checker u_csor_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_data   (i_in_data),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);
